FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the sector transfer sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never hold outside reset.
`define CHS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define CHS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/chs_pkg.sv
// Types and constants shared by the sector transfer sequencer modules.
package chs_pkg;

    localparam int DIV_W      = 32;
    localparam int DIV_CNT_W  = $clog2(DIV_W);
    localparam int RETRY_W    = 3;
    localparam int CHUNK_W    = 7;
    localparam int IDX_W      = 3;
    localparam int CFG_DATA_W = 20;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 96;

    localparam int DEF_RETRIES    = 6;
    localparam int DEF_COUNT_BITS = 16;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] CFG_SPT    = 3'd0;
    localparam logic [IDX_W-1:0] CFG_HEADS  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_SHIFT  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_BOUNCE = 3'd3;
    localparam logic [IDX_W-1:0] CFG_MAXXFR = 3'd4;
    localparam logic [IDX_W-1:0] CFG_DRIVE  = 3'd5;

    localparam logic [5:0]  RST_SPT    = 6'd63;
    localparam logic [8:0]  RST_HEADS  = 9'd255;
    localparam logic [3:0]  RST_SHIFT  = 4'd9;
    localparam logic [19:0] RST_BOUNCE = 20'd0;
    localparam logic [6:0]  RST_LIMIT  = 7'd127;
    localparam logic [7:0]  RST_DRIVE  = 8'd128;

    localparam logic [31:0] BOUNCE_LIMIT = 32'h000F_0000;
    localparam logic [16:0] BOUNDARY     = 17'h1_0000;

    localparam logic MODE_START    = 1'b0;
    localparam logic MODE_COMPLETE = 1'b1;
    localparam logic KIND_ISSUE    = 1'b0;
    localparam logic KIND_DONE     = 1'b1;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } div_rsp_t;

endpackage

FILE: rtl/core/chs_sector_transfer_sequencer_core.sv
// Sector transfer sequencer: request splitting, retry control and CHS translation.
// A command word is computed by two divisions, by sectors per track and then by heads;
// a finishing word needs none, and when retries run out on a chunk that cannot be halved
// it is registered by the edge that takes the input word.
// One input word is in work at a time; the next is taken from the edge after the result goes.
// rst_n clears all state asynchronously and loads the register defaults.
`include "assert_macros.svh"

module chs_sector_transfer_sequencer_core
    import chs_pkg::*;
#(
    parameter int RETRIES    = DEF_RETRIES,
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // start_lba[31:0], sector_count[47:32], buffer_address[79:48], write[80],
    // call_failed[81], zero fill above
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // mode[0]
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // function_code[1:0], chunk_sectors[8:2], cylinder_low[16:9],
    // cyl_high_and_sector[24:17], head[32:25], drive[40:33],
    // target_address[72:41], copy_via_bounce[73], sectors_done[89:74],
    // failed[90], zero fill above
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // kind[0]
    output logic                  m_axis_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHUNK = 3'd1;
    localparam logic [2:0] ST_DIVS  = 3'd2;
    localparam logic [2:0] ST_WAITS = 3'd3;
    localparam logic [2:0] ST_DIVH  = 3'd4;
    localparam logic [2:0] ST_WAITH = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    // Configuration registers.
    logic [5:0]  spt_reg;
    logic [8:0]  heads_reg;
    logic [3:0]  shift_reg;
    logic [19:0] bounce_reg;
    logic [7:0]  drive_reg;

    logic [2:0]            state_reg,     state_next;
    logic [31:0]           lba_reg,       lba_next;
    logic [COUNT_BITS-1:0] remaining_reg, remaining_next;
    logic [COUNT_BITS-1:0] done_reg,      done_next;
    logic [31:0]           cp_reg,        cp_next;
    logic                  direct_reg,    direct_next;
    logic                  wr_reg,        wr_next;
    logic [CHUNK_W-1:0]    chunk_reg,     chunk_next;
    logic [RETRY_W-1:0]    retries_reg,   retries_next;
    logic [CHUNK_W-1:0]    limit_reg,     limit_next;
    logic                  busy_reg,      busy_next;
    logic [7:0]            sec_reg,       sec_next;
    logic [OUT_DATA_W-1:0] out_data_reg,  out_data_next;
    logic                  out_kind_reg,  out_kind_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic                  s_fire;
    logic [16:0]           cp_room;
    logic [16:0]           bb_room;
    logic                  direct_ok;
    logic [16:0]           room;
    logic [31:0]           target;
    logic                  via;
    logic [CHUNK_W-1:0]    c_lim;
    logic [CHUNK_W-1:0]    c_room;
    logic [CHUNK_W-1:0]    chunk_half;
    logic [1:0]            fcode;
    logic [15:0]           done16;
    logic [7:0]            sec_plus;
    logic [OUT_DATA_W-1:0] fin_ok_word;
    logic [OUT_DATA_W-1:0] fin_fail_word;
    logic [OUT_DATA_W-1:0] issue_word;

    chs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign cfg_ready     = 1'b1;

    // Routing: direct to the caller buffer while it is low enough and a whole
    // sector still fits before the 64 KiB boundary, else via the bounce buffer.
    always_comb
    begin
        cp_room   = (BOUNDARY - {1'b0, cp_reg[15:0]}) >> shift_reg;
        bb_room   = (BOUNDARY - {1'b0, bounce_reg[15:0]}) >> shift_reg;
        direct_ok = direct_reg && (cp_room != '0);
        room      = direct_ok ? cp_room : bb_room;
        target    = direct_ok ? cp_reg : {12'd0, bounce_reg};
        via       = direct_ok ? 1'b0 : ({12'd0, bounce_reg} != cp_reg);
        c_lim     = (remaining_reg > COUNT_BITS'(limit_reg)) ? limit_reg
                                                             : remaining_reg[CHUNK_W-1:0];
        c_room    = ({10'd0, c_lim} > room) ? room[CHUNK_W-1:0] : c_lim;
    end

    always_comb
    begin
        chunk_half    = chunk_reg >> 1;
        fcode         = {1'b1, wr_reg};
        done16        = 16'(done_reg);
        sec_plus      = sec_reg + 8'd1;
        fin_ok_word   = {5'd0, 1'b0, done16, 1'b0, 32'd0, 32'd0, 7'd0, fcode};
        fin_fail_word = {5'd0, 1'b1, done16, 1'b0, 32'd0, 32'd0, 7'd0, fcode};
        issue_word    = {5'd0, 1'b0, 16'd0, via, target, drive_reg,
                         div_rsp.remainder[7:0],
                         ({div_rsp.quotient[9:8], 6'd0} | sec_plus),
                         div_rsp.quotient[7:0], chunk_reg, fcode};
    end

    always_comb
    begin
        state_next     = state_reg;
        lba_next       = lba_reg;
        remaining_next = remaining_reg;
        done_next      = done_reg;
        cp_next        = cp_reg;
        direct_next    = direct_reg;
        wr_next        = wr_reg;
        chunk_next     = chunk_reg;
        retries_next   = retries_reg;
        limit_next     = limit_reg;
        busy_next      = busy_reg;
        sec_next       = sec_reg;
        out_data_next  = out_data_reg;
        out_kind_next  = out_kind_reg;

        div_req.start    = 1'b0;
        div_req.dividend = (state_reg == ST_DIVH) ? div_rsp.quotient : lba_reg;
        div_req.divisor  = (state_reg == ST_DIVH) ? {23'd0, heads_reg} : {26'd0, spt_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    if (s_axis_tuser == MODE_START)
                    begin
                        lba_next       = s_axis_tdata[31:0];
                        remaining_next = COUNT_BITS'(s_axis_tdata[47:32]);
                        cp_next        = s_axis_tdata[79:48];
                        direct_next    = (s_axis_tdata[79:48] <= BOUNCE_LIMIT);
                        wr_next        = s_axis_tdata[80];
                        done_next      = '0;
                        state_next     = ST_CHUNK;
                    end
                    else if (!busy_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (!s_axis_tdata[81])
                    begin
                        cp_next        = cp_reg + (32'(chunk_reg) << shift_reg);
                        lba_next       = lba_reg + 32'(chunk_reg);
                        remaining_next = remaining_reg - COUNT_BITS'(chunk_reg);
                        done_next      = done_reg + COUNT_BITS'(chunk_reg);
                        state_next     = ST_CHUNK;
                    end
                    else if (retries_reg != '0)
                    begin
                        retries_next = retries_reg - RETRY_W'(1);
                        state_next   = ST_DIVS;
                    end
                    else if (chunk_half != '0)
                    begin
                        chunk_next   = chunk_half;
                        limit_next   = chunk_half;
                        retries_next = RETRY_W'(RETRIES);
                        state_next   = ST_DIVS;
                    end
                    else
                    begin
                        chunk_next    = '0;
                        busy_next     = 1'b0;
                        out_kind_next = KIND_DONE;
                        out_data_next = fin_fail_word;
                        state_next    = ST_OUT;
                    end
                end
            end
            ST_CHUNK:
            begin
                if (remaining_reg == '0)
                begin
                    busy_next     = 1'b0;
                    out_kind_next = KIND_DONE;
                    out_data_next = fin_ok_word;
                    state_next    = ST_OUT;
                end
                else if (c_room == '0)
                begin
                    chunk_next    = '0;
                    busy_next     = 1'b0;
                    out_kind_next = KIND_DONE;
                    out_data_next = fin_fail_word;
                    state_next    = ST_OUT;
                end
                else
                begin
                    chunk_next   = c_room;
                    retries_next = RETRY_W'(RETRIES);
                    busy_next    = 1'b1;
                    state_next   = ST_DIVS;
                end
            end
            ST_DIVS:
            begin
                div_req.start = 1'b1;
                state_next    = ST_WAITS;
            end
            ST_WAITS:
            begin
                if (div_rsp.done)
                begin
                    sec_next   = div_rsp.remainder[7:0];
                    state_next = ST_DIVH;
                end
            end
            ST_DIVH:
            begin
                // The track number is still held as the divider's quotient.
                div_req.start = 1'b1;
                state_next    = ST_WAITH;
            end
            ST_WAITH:
            begin
                if (div_rsp.done)
                begin
                    out_kind_next = KIND_ISSUE;
                    out_data_next = issue_word;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // The transfer limit register is the working limit itself; a write of it wins over a halving.
        if (cfg_valid && cfg_ready && (cfg_index == CFG_MAXXFR))
        begin
            limit_next = cfg_data[CHUNK_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spt_reg    <= RST_SPT;
            heads_reg  <= RST_HEADS;
            shift_reg  <= RST_SHIFT;
            bounce_reg <= RST_BOUNCE;
            drive_reg  <= RST_DRIVE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SPT:    spt_reg    <= cfg_data[5:0];
                CFG_HEADS:  heads_reg  <= cfg_data[8:0];
                CFG_SHIFT:  shift_reg  <= cfg_data[3:0];
                CFG_BOUNCE: bounce_reg <= cfg_data;
                CFG_DRIVE:  drive_reg  <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lba_reg       <= '0;
            remaining_reg <= '0;
            done_reg      <= '0;
            cp_reg        <= '0;
            direct_reg    <= 1'b0;
            wr_reg        <= 1'b0;
            chunk_reg     <= '0;
            retries_reg   <= RETRY_W'(RETRIES);
            limit_reg     <= RST_LIMIT;
            busy_reg      <= 1'b0;
            sec_reg       <= '0;
            out_data_reg  <= '0;
            out_kind_reg  <= KIND_ISSUE;
        end
        else
        begin
            state_reg     <= state_next;
            lba_reg       <= lba_next;
            remaining_reg <= remaining_next;
            done_reg      <= done_next;
            cp_reg        <= cp_next;
            direct_reg    <= direct_next;
            wr_reg        <= wr_next;
            chunk_reg     <= chunk_next;
            retries_reg   <= retries_next;
            limit_reg     <= limit_next;
            busy_reg      <= busy_next;
            sec_reg       <= sec_next;
            out_data_reg  <= out_data_next;
            out_kind_reg  <= out_kind_next;
        end
    end

    `CHS_ASSERT_NEVER(a_no_take_while_pending, clk, rst_n, s_axis_tready && m_axis_tvalid, "input taken while a result word waits")
    `CHS_ASSERT_IMPL(a_issue_has_chunk, clk, rst_n, m_axis_tvalid && (m_axis_tuser == KIND_ISSUE), m_axis_tdata[8:2] != '0, "command issued with an empty chunk")
    `CHS_ASSERT_IMPL(a_div_done_in_wait, clk, rst_n, div_rsp.done, (state_reg == ST_WAITS) || (state_reg == ST_WAITH), "divider finished outside a wait state")
    `CHS_ASSERT_NEVER(a_retry_bound, clk, rst_n, retries_reg > RETRY_W'(RETRIES), "retry count above its reload value")

endmodule

FILE: rtl/core/chs_div.sv
// Shared restoring divider, one quotient bit per cycle.
module chs_div
    import chs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 run_reg;
    logic                 done_reg;

    logic [DIV_W:0]   partial;
    logic [DIV_W+1:0] diff;
    logic             take_sub;
    logic [DIV_W-1:0] rem_step;
    logic             last_step;

    // A zero divisor always subtracts, giving an all-ones quotient and
    // leaving the dividend as remainder.
    always_comb
    begin
        partial   = {rem_reg, quo_reg[DIV_W-1]};
        diff      = {1'b0, partial} - {2'b00, dvs_reg};
        take_sub  = !diff[DIV_W+1];
        rem_step  = take_sub ? diff[DIV_W-1:0] : partial[DIV_W-1:0];
        last_step = (cnt_reg == DIV_CNT_W'(DIV_W - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                quo_reg <= req.dividend;
                rem_reg <= '0;
                dvs_reg <= req.divisor;
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                quo_reg <= {quo_reg[DIV_W-2:0], take_sub};
                rem_reg <= rem_step;
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (last_step)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: tb/tb_chs_sector_transfer_sequencer_core.sv
// Self-checking testbench for the CHS sector transfer sequencer core.
`timescale 1ns / 1ps

module tb_chs_sector_transfer_sequencer_core;
    import chs_pkg::*;

    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef struct packed {
        logic [5:0]  spt;
        logic [8:0]  heads;
        logic [3:0]  shift;
        logic [19:0] bounce;
        logic [7:0]  drive;
        logic [31:0] lba;
        logic [15:0] remaining;
        logic [15:0] done;
        logic [31:0] ptr;
        logic        direct;
        logic        wr;
        logic [6:0]  chunk;
        logic [2:0]  retries;
        logic [6:0]  limit;
        logic        busy;
    } seq_state_t;

    typedef struct packed {
        logic        mode;
        logic [31:0] lba;
        logic [15:0] count;
        logic [31:0] buf_addr;
        logic        wr;
        logic        fail;
        logic        drain;
    } req_word_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  fcode;
        logic [6:0]  chunk;
        logic [7:0]  cyl_low;
        logic [7:0]  cyl_sec;
        logic [7:0]  head;
        logic [7:0]  drive;
        logic [31:0] target;
        logic        via;
        logic [15:0] done;
        logic        failed;
    } cmd_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    seq_state_t live_state;
    seq_state_t gen_state;
    req_word_t  request_words[$];
    cmd_word_t  awaited_words[$];
    req_word_t  on_bus;
    int         words_queued = 0;
    int         words_taken = 0;
    int         gen_results = 0;
    int         mismatches = 0;
    int         cycle_count = 0;
    int         sender_idle = 0;
    int         receiver_idle = 0;

    chs_sector_transfer_sequencer_core DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    function automatic seq_state_t reset_state();
        seq_state_t m;
        m         = '0;
        m.spt     = RST_SPT;
        m.heads   = RST_HEADS;
        m.shift   = RST_SHIFT;
        m.bounce  = RST_BOUNCE;
        m.drive   = RST_DRIVE;
        m.retries = 3'(DEF_RETRIES);
        m.limit   = RST_LIMIT;
        return m;
    endfunction

    function automatic void apply_reg(inout seq_state_t m, input logic [IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_SPT:    m.spt = value[5:0];
            CFG_HEADS:  m.heads = value[8:0];
            CFG_SHIFT:  m.shift = value[3:0];
            CFG_BOUNCE: m.bounce = value[19:0];
            CFG_MAXXFR: m.limit = value[6:0];
            CFG_DRIVE:  m.drive = value[7:0];
            default: ;
        endcase
    endfunction

    // Direct transfer while at least one sector fits before the 64 KiB boundary,
    // otherwise through the bounce buffer.
    function automatic logic [31:0] route_target(input seq_state_t m, output logic via,
                                                 output logic [31:0] room);
        logic [31:0] fits;
        fits = (32'h10000 - {16'h0, m.ptr[15:0]}) >> m.shift;
        if (m.direct && fits != 0)
        begin
            via  = 1'b0;
            room = fits;
            return m.ptr;
        end
        room = (32'h10000 - {16'h0, m.bounce[15:0]}) >> m.shift;
        via  = ({12'h0, m.bounce} != m.ptr);
        return {12'h0, m.bounce};
    endfunction

    function automatic cmd_word_t chs_command(input seq_state_t m);
        cmd_word_t   w;
        logic        via;
        logic [31:0] room;
        logic [31:0] tgt;
        logic [31:0] trk;
        logic [31:0] sec;
        logic [31:0] cyl;
        logic [31:0] hd;
        logic [31:0] sec_plus;
        tgt = route_target(m, via, room);
        // A zero divisor behaves as a plain hardware divider does.
        if (m.spt == 0)
        begin
            trk = '1;
            sec = m.lba;
        end
        else
        begin
            trk = m.lba / m.spt;
            sec = m.lba % m.spt;
        end
        if (m.heads == 0)
        begin
            cyl = '1;
            hd  = trk;
        end
        else
        begin
            cyl = trk / m.heads;
            hd  = trk % m.heads;
        end
        sec_plus  = {16'h0, sec[15:0]} + 32'd1;
        w         = '0;
        w.kind    = KIND_ISSUE;
        w.fcode   = {1'b1, m.wr};
        w.chunk   = m.chunk;
        w.cyl_low = cyl[7:0];
        w.cyl_sec = {cyl[9:8], 6'b0} | sec_plus[7:0];
        w.head    = hd[7:0];
        w.drive   = m.drive;
        w.target  = tgt;
        w.via     = via;
        return w;
    endfunction

    function automatic cmd_word_t finish_word(inout seq_state_t m, input logic fail);
        cmd_word_t w;
        w        = '0;
        m.busy   = 1'b0;
        w.kind   = KIND_DONE;
        w.fcode  = {1'b1, m.wr};
        w.done   = m.done;
        w.failed = fail;
        return w;
    endfunction

    function automatic cmd_word_t issue_or_finish(inout seq_state_t m);
        logic        via;
        logic [31:0] room;
        logic [31:0] size;
        if (m.remaining == 0)
            return finish_word(m, 1'b0);
        size = {16'h0, m.remaining};
        if (size > {25'h0, m.limit})
            size = {25'h0, m.limit};
        void'(route_target(m, via, room));
        if (size > room)
            size = room;
        if (size == 0)
        begin
            m.chunk = '0;
            return finish_word(m, 1'b1);
        end
        m.chunk   = size[6:0];
        m.retries = 3'(DEF_RETRIES);
        m.busy    = 1'b1;
        return chs_command(m);
    endfunction

    // Returns 1 when the word produces a result word.
    function automatic logic advance_request(inout seq_state_t m, input req_word_t r,
                                             output cmd_word_t w);
        w = '0;
        if (r.mode == MODE_START)
        begin
            m.lba       = r.lba;
            m.remaining = r.count;
            m.ptr       = r.buf_addr;
            m.direct    = (r.buf_addr <= BOUNCE_LIMIT);
            m.wr        = r.wr;
            m.done      = '0;
            w = issue_or_finish(m);
            return 1'b1;
        end
        if (!m.busy)
            return 1'b0;
        if (!r.fail)
        begin
            m.ptr       = m.ptr + ({25'h0, m.chunk} << m.shift);
            m.lba       = m.lba + {25'h0, m.chunk};
            m.remaining = m.remaining - {9'h0, m.chunk};
            m.done      = m.done + {9'h0, m.chunk};
            w = issue_or_finish(m);
        end
        else if (m.retries != 0)
        begin
            m.retries = m.retries - 3'd1;
            w = chs_command(m);
        end
        else
        begin
            // Retries exhausted: halve the chunk and make it the new limit, or fail once it reaches zero.
            m.chunk = m.chunk >> 1;
            if (m.chunk != 0)
            begin
                m.limit   = m.chunk;
                m.retries = 3'(DEF_RETRIES);
                w = chs_command(m);
            end
            else
                w = finish_word(m, 1'b1);
        end
        return 1'b1;
    endfunction

    function automatic void queue_word(input logic mode, input logic [31:0] lba,
                                       input logic [15:0] count, input logic [31:0] buf_addr,
                                       input logic wr, input logic fail, input logic drain);
        req_word_t r;
        cmd_word_t w;
        r = '{mode, lba, count, buf_addr, wr, fail, drain};
        request_words.push_back(r);
        words_queued++;
        if (advance_request(gen_state, r, w))
            gen_results++;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t ns] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        apply_reg(live_state, idx, value);
        apply_reg(gen_state, idx, value);
    endtask

    task automatic load_settings(input int spt, input int heads, input int shift,
                                 input int bounce, input int limit, input int drive);
        write_reg(CFG_SPT, CFG_DATA_W'(spt));
        write_reg(CFG_HEADS, CFG_DATA_W'(heads));
        write_reg(CFG_SHIFT, CFG_DATA_W'(shift));
        write_reg(CFG_BOUNCE, CFG_DATA_W'(bounce));
        write_reg(CFG_MAXXFR, CFG_DATA_W'(limit));
        write_reg(CFG_DRIVE, CFG_DATA_W'(drive));
    endtask

    // A completion while idle gives no word, so let the core settle after the last one.
    task automatic wait_idle();
        while (words_taken != words_queued || awaited_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin : word_driver
        cmd_word_t predicted;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (advance_request(live_state, on_bus, predicted))
                    awaited_words.push_back(predicted);
                words_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                // A word marked for draining waits until every result word is back.
                if (request_words.size() != 0 && $urandom_range(99) >= sender_idle
                    && !(request_words[0].drain && awaited_words.size() != 0))
                begin
                    on_bus = request_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {6'b0, on_bus.fail, on_bus.wr, on_bus.buf_addr,
                                      on_bus.count, on_bus.lba};
                    s_axis_tuser  <= on_bus.mode;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        cmd_word_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_words.size() == 0)
                    report_mismatch("result word with nothing expected");
                else
                begin
                    want = awaited_words.pop_front();
                    compare_field("kind", 32'(m_axis_tuser), 32'(want.kind));
                    compare_field("function_code", 32'(m_axis_tdata[1:0]), 32'(want.fcode));
                    compare_field("chunk_sectors", 32'(m_axis_tdata[8:2]), 32'(want.chunk));
                    compare_field("cylinder_low", 32'(m_axis_tdata[16:9]), 32'(want.cyl_low));
                    compare_field("cyl_high_and_sector", 32'(m_axis_tdata[24:17]),
                                  32'(want.cyl_sec));
                    compare_field("head", 32'(m_axis_tdata[32:25]), 32'(want.head));
                    compare_field("drive", 32'(m_axis_tdata[40:33]), 32'(want.drive));
                    compare_field("target_address", m_axis_tdata[72:41], want.target);
                    compare_field("copy_via_bounce", 32'(m_axis_tdata[73]), 32'(want.via));
                    compare_field("sectors_done", 32'(m_axis_tdata[89:74]), 32'(want.done));
                    compare_field("failed", 32'(m_axis_tdata[90]), 32'(want.failed));
                    compare_field("zero fill", 32'(m_axis_tdata[OUT_DATA_W-1:91]), 32'd0);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= receiver_idle);
        end
    end

    initial
    begin : stimulus
        int          phase;
        int          target;
        int          steps;
        int          burst;
        int          i;
        logic [31:0] lba;
        logic [15:0] count;
        logic [31:0] buf_addr;
        logic        fail;

        live_state = reset_state();
        gen_state  = reset_state();
        sender_idle   = 31;
        receiver_idle = 87;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: idle completion, empty request, wrapping request with
        // retries and a halving, then a restart while busy across a boundary.
        queue_word(MODE_COMPLETE, 32'h0, 16'h0, 32'h0, 1'b0, 1'b0, 1'b0);
        queue_word(MODE_START, 32'h0, 16'h0, 32'h0, 1'b0, 1'b0, 1'b0);
        queue_word(MODE_START, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
        queue_word(MODE_COMPLETE, 32'h0, 16'h0, 32'h0, 1'b0, 1'b0, 1'b0);
        for (i = 0; i < 7; i++)
            queue_word(MODE_COMPLETE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
        queue_word(MODE_START, 32'd12345678, 16'd3, 32'h0000_FE00, 1'b0, 1'b0, 1'b0);
        queue_word(MODE_COMPLETE, 32'h0, 16'h0, 32'h0, 1'b0, 1'b0, 1'b0);
        queue_word(MODE_COMPLETE, 32'h0, 16'h0, 32'h0, 1'b0, 1'b0, 1'b0);
        queue_word(MODE_COMPLETE, 32'h0, 16'h0, 32'h0, 1'b0, 1'b0, 1'b0);
        wait_idle();

        // Zero divisors, widest shift and a bounce buffer with no room left.
        load_settings(0, 0, 15, 20'hFFFFF, 1, 0);
        queue_word(MODE_START, 32'hDEAD_BEEF, 16'd9, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
        queue_word(MODE_START, 32'hDEAD_BEEF, 16'd10, 32'h0000_0100, 1'b0, 1'b0, 1'b0);
        for (i = 0; i < 7; i++)
            queue_word(MODE_COMPLETE, 32'h0, 16'h0, 32'h0, 1'b0, 1'b1, 1'b0);
        wait_idle();

        for (phase = 0; phase < 9; phase++)
        begin
            if (phase == 3)
            begin
                sender_idle   = 87;
                receiver_idle = 31;
            end
            if (phase == 6)
            begin
                sender_idle   = 0;
                receiver_idle = 0;
            end
            case (phase)
                0: load_settings(63, 255, 9, 20'h07C00, 127, 8'h80);
                1: load_settings(1, 1, 12, 20'hF8000, 127, 8'hFF);
                2: load_settings(17, 256, 11, 20'h9F000, 64, 8'h81);
                3: load_settings(63, 511, 0, 20'h00000, 1, 8'h00);
                4: load_settings(32, 16, 10, 20'h12345, 0, 8'hAA);
                default: load_settings($urandom_range(63), $urandom_range(511),
                                       $urandom_range(15), $urandom_range(20'hFFFFF),
                                       $urandom_range(1, 127), $urandom_range(255));
            endcase
            // A zero transfer limit refuses every non-empty request, so that phase stays short.
            target = gen_results + ((phase == 4) ? 30 : 90);
            while (gen_results < target)
            begin
                if ($urandom_range(99) < 6)
                begin
                    queue_word(1'($urandom_range(1)), $urandom, 16'($urandom_range(16'hFFFF)),
                               $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0);
                    continue;
                end
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: lba = $urandom;
                    5, 6, 7:       lba = $urandom_range(5000);
                    default:       lba = 32'hFFFF_FFFF - $urandom_range(300);
                endcase
                case ($urandom_range(9))
                    0:       count = 16'($urandom_range(3));
                    1, 2, 3, 4, 5: count = 16'($urandom_range(1, 300));
                    6, 7:    count = 16'($urandom_range(16'hFFFF));
                    8:       count = 16'(32'hFFFF - $urandom_range(1));
                    default: count = 16'($urandom_range(1, 8));
                endcase
                case ($urandom_range(9))
                    0, 1, 2: buf_addr = $urandom;
                    3, 4:    buf_addr = $urandom_range(32'hF0000);
                    5:       buf_addr = ($urandom_range(14) << 16)
                                        | $urandom_range(32'hFF00, 32'hFFFF);
                    6:       buf_addr = 32'hF0000 + $urandom_range(1);
                    7:       buf_addr = {12'h0, gen_state.bounce};
                    8:       buf_addr = 32'hFFFF_FFFF - $urandom_range(32'h1FFFF);
                    default: buf_addr = $urandom_range(32'hFFFF);
                endcase
                queue_word(MODE_START, lba, count, buf_addr, 1'($urandom_range(1)),
                           1'($urandom_range(1)), ($urandom_range(99) < 3));
                // Completions until the request ends, or give up and restart while busy.
                steps = $urandom_range(2, 40);
                burst = 0;
                while (gen_state.busy && steps > 0)
                begin
                    if (burst == 0 && $urandom_range(99) < 8)
                        burst = $urandom_range(1, 9);
                    fail = (burst != 0) || ($urandom_range(99) < 4);
                    if (burst != 0)
                        burst--;
                    queue_word(MODE_COMPLETE, $urandom, 16'($urandom_range(16'hFFFF)), $urandom,
                               1'($urandom_range(1)), fail, 1'b0);
                    steps--;
                end
            end
            wait_idle();
        end

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: chs_sector_transfer_sequencer_core.f
+incdir+rtl/core
rtl/core/chs_pkg.sv
rtl/core/chs_div.sv
rtl/core/chs_sector_transfer_sequencer_core.sv
tb/tb_chs_sector_transfer_sequencer_core.sv
